[sv/hrlc_pkg.sv]
package hrlc_pkg;

  localparam logic [2:0] PH_METHOD = 3'd0;
  localparam logic [2:0] PH_GAP    = 3'd1;
  localparam logic [2:0] PH_PATH   = 3'd2;
  localparam logic [2:0] PH_QUERY  = 3'd3;
  localparam logic [2:0] PH_AFTER  = 3'd4;

  localparam logic [1:0] ESC_IDLE  = 2'd0;
  localparam logic [1:0] ESC_PCT   = 2'd1;
  localparam logic [1:0] ESC_DIGIT = 2'd2;

  localparam logic [2:0] MATCH_FAIL = 3'd7;
  localparam logic [2:0] GET_LEN    = 3'd3;
  localparam logic [2:0] INFO_LEN   = 3'd4;
  localparam logic [3:0] PREFIX_LEN = 4'd9;

  localparam logic [2:0] OUT_RUN       = 3'd0;
  localparam logic [2:0] OUT_INFO      = 3'd1;
  localparam logic [2:0] OUT_BAD_QUERY = 3'd2;
  localparam logic [2:0] OUT_BAD_NAME  = 3'd3;
  localparam logic [2:0] OUT_REJECT    = 3'd4;

  localparam logic [2:0] ERR_NONE       = 3'd0;
  localparam logic [2:0] ERR_MALFORMED  = 3'd1;
  localparam logic [2:0] ERR_NOT_GET    = 3'd2;
  localparam logic [2:0] ERR_BAD_NAME   = 3'd3;
  localparam logic [2:0] ERR_QUERY_LONG = 3'd4;

  localparam logic [7:0] CH_NUL   = 8'd0;
  localparam logic [7:0] CH_TAB   = 8'd9;
  localparam logic [7:0] CH_LF    = 8'd10;
  localparam logic [7:0] CH_CR    = 8'd13;
  localparam logic [7:0] CH_SP    = 8'd32;
  localparam logic [7:0] CH_PCT   = 8'h25;
  localparam logic [7:0] CH_SLASH = 8'h2f;
  localparam logic [7:0] CH_QM    = 8'h3f;

  localparam int LEN_W = 10;

  typedef struct packed {
    logic [2:0] phase;
    logic [2:0] method_match;
    logic [1:0] esc;
    logic [7:0] held;
    logic       first_seen;
    logic       first_slash;
    logic       name_ok;
    logic       name_cut;
    logic [2:0] info_match;
    logic       prefix_ok;
    logic       query_ok;
    logic       line_cut;
    logic       after_cr;
  } line_state_t;

  typedef struct packed {
    logic [2:0]       outcome;
    logic [2:0]       error_code;
    logic [LEN_W-1:0] name_length;
    logic [LEN_W-1:0] query_length;
  } verdict_t;

  function automatic line_state_t clear_state();
    line_state_t s;
    s = '0;
    s.phase     = PH_METHOD;
    s.esc       = ESC_IDLE;
    s.name_ok   = 1'b1;
    s.prefix_ok = 1'b1;
    s.query_ok  = 1'b1;
    return s;
  endfunction

  function automatic logic is_sep(input logic [7:0] b);
    return (b == CH_SP) || (b == CH_TAB);
  endfunction

  function automatic logic is_word(input logic [7:0] b);
    return (b >= "0" && b <= "9") || (b >= "a" && b <= "z") ||
           (b >= "A" && b <= "Z") || (b == "_");
  endfunction

  function automatic logic is_hex(input logic [7:0] b);
    return (b >= "0" && b <= "9") || (b >= "a" && b <= "f") ||
           (b >= "A" && b <= "F");
  endfunction

  function automatic logic [3:0] hex_val(input logic [7:0] b);
    logic [7:0] v;
    v = 8'd0;
    if (b >= "0" && b <= "9") v = b - 8'h30;
    else if (b >= "a" && b <= "f") v = b - 8'h57;
    else if (b >= "A" && b <= "F") v = b - 8'h37;
    return v[3:0];
  endfunction

  function automatic logic [7:0] to_lower(input logic [7:0] b);
    return (b >= "A" && b <= "Z") ? b + 8'd32 : b;
  endfunction

  function automatic logic [7:0] get_char(input logic [1:0] i);
    logic [7:0] c;
    case (i)
      2'd0:    c = "g";
      2'd1:    c = "e";
      2'd2:    c = "t";
      default: c = 8'd0;
    endcase
    return c;
  endfunction

  function automatic logic [7:0] info_char(input logic [1:0] i);
    logic [7:0] c;
    case (i)
      2'd0:    c = "i";
      2'd1:    c = "n";
      2'd2:    c = "f";
      default: c = "o";
    endcase
    return c;
  endfunction

  function automatic logic [7:0] prefix_char(input logic [3:0] i);
    logic [7:0] c;
    case (i)
      4'd0:    c = "f";
      4'd1:    c = "i";
      4'd2:    c = "l";
      4'd3:    c = "e";
      4'd4:    c = "n";
      4'd5:    c = "a";
      4'd6:    c = "m";
      4'd7:    c = "e";
      4'd8:    c = "=";
      default: c = 8'd0;
    endcase
    return c;
  endfunction

endpackage

[sv/hrlc_parse.sv]
module hrlc_parse #(
  parameter int NAME_LIMIT = 1024,
  localparam int CW = $clog2(NAME_LIMIT)
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      step,
  input  logic [7:0]                byte_in,
  output hrlc_pkg::line_state_t     st,
  output logic [CW-1:0]             name_count,
  output logic [CW-1:0]             query_count,
  output logic                      emit
);

  localparam logic [CW-1:0] LEN_CAP = CW'(NAME_LIMIT - 1);

  hrlc_pkg::line_state_t n;
  logic [CW-1:0]         nc;
  logic [CW-1:0]         qc;
  logic [7:0]            dec [3];
  logic [2:0]            dec_v;
  logic                  path_go;
  logic                  flush_go;
  logic [7:0]            lc;

  assign emit = (byte_in == hrlc_pkg::CH_CR) ||
                (byte_in == hrlc_pkg::CH_LF && !st.after_cr);

  always_comb begin
    n        = st;
    nc       = name_count;
    qc       = query_count;
    dec_v    = '0;
    dec[0]   = '0;
    dec[1]   = '0;
    dec[2]   = '0;
    path_go  = 1'b0;
    flush_go = 1'b0;
    lc       = hrlc_pkg::to_lower(byte_in);
    n.after_cr = 1'b0;

    if (byte_in == hrlc_pkg::CH_LF && st.after_cr) begin
      // LF of a CR LF pair
    end else if (byte_in == hrlc_pkg::CH_LF || byte_in == hrlc_pkg::CH_CR) begin
      n          = hrlc_pkg::clear_state();
      n.after_cr = (byte_in == hrlc_pkg::CH_CR);
      nc         = '0;
      qc         = '0;
    end else if (st.line_cut) begin
      // rest of line ignored
    end else if (byte_in == hrlc_pkg::CH_NUL) begin
      n.line_cut = 1'b1;
    end else begin
      case (st.phase)
        hrlc_pkg::PH_METHOD: begin
          if (hrlc_pkg::is_sep(byte_in)) begin
            n.phase = hrlc_pkg::PH_GAP;
          end else if (st.method_match < hrlc_pkg::GET_LEN &&
                       lc == hrlc_pkg::get_char(st.method_match[1:0])) begin
            n.method_match = st.method_match + 3'd1;
          end else begin
            n.method_match = hrlc_pkg::MATCH_FAIL;
          end
        end
        hrlc_pkg::PH_GAP: begin
          if (!hrlc_pkg::is_sep(byte_in)) begin
            if (byte_in == hrlc_pkg::CH_QM) begin
              n.phase = hrlc_pkg::PH_QUERY;
            end else begin
              n.phase = hrlc_pkg::PH_PATH;
              path_go = 1'b1;
            end
          end
        end
        hrlc_pkg::PH_PATH: begin
          if (hrlc_pkg::is_sep(byte_in)) begin
            flush_go = 1'b1;
            n.phase  = hrlc_pkg::PH_AFTER;
          end else if (byte_in == hrlc_pkg::CH_QM) begin
            flush_go = 1'b1;
            n.phase  = hrlc_pkg::PH_QUERY;
          end else begin
            path_go = 1'b1;
          end
        end
        hrlc_pkg::PH_QUERY: begin
          if (hrlc_pkg::is_sep(byte_in)) begin
            n.phase = hrlc_pkg::PH_AFTER;
          end else begin
            if (qc < CW'(hrlc_pkg::PREFIX_LEN)) begin
              if (byte_in != hrlc_pkg::prefix_char(qc[3:0])) n.prefix_ok = 1'b0;
            end else if (!hrlc_pkg::is_word(byte_in)) begin
              n.query_ok = 1'b0;
            end
            if (qc < LEN_CAP) qc = qc + 1'b1;
          end
        end
        default: begin
        end
      endcase
    end

    // percent decoding: up to three decoded bytes per input byte
    if (flush_go) begin
      dec_v[0] = (st.esc != hrlc_pkg::ESC_IDLE);
      dec[0]   = hrlc_pkg::CH_PCT;
      dec_v[1] = (st.esc == hrlc_pkg::ESC_DIGIT);
      dec[1]   = st.held;
      n.esc    = hrlc_pkg::ESC_IDLE;
    end else if (path_go) begin
      case (st.esc)
        hrlc_pkg::ESC_PCT: begin
          if (hrlc_pkg::is_hex(byte_in)) begin
            n.held = byte_in;
            n.esc  = hrlc_pkg::ESC_DIGIT;
          end else begin
            dec_v[0] = 1'b1;
            dec[0]   = hrlc_pkg::CH_PCT;
            if (byte_in == hrlc_pkg::CH_PCT) begin
              n.esc = hrlc_pkg::ESC_PCT;
            end else begin
              n.esc    = hrlc_pkg::ESC_IDLE;
              dec_v[1] = 1'b1;
              dec[1]   = byte_in;
            end
          end
        end
        hrlc_pkg::ESC_DIGIT: begin
          if (hrlc_pkg::is_hex(byte_in)) begin
            dec_v[0] = 1'b1;
            dec[0]   = {hrlc_pkg::hex_val(st.held), hrlc_pkg::hex_val(byte_in)};
            n.esc    = hrlc_pkg::ESC_IDLE;
          end else begin
            dec_v[0] = 1'b1;
            dec[0]   = hrlc_pkg::CH_PCT;
            dec_v[1] = 1'b1;
            dec[1]   = st.held;
            if (byte_in == hrlc_pkg::CH_PCT) begin
              n.esc = hrlc_pkg::ESC_PCT;
            end else begin
              n.esc    = hrlc_pkg::ESC_IDLE;
              dec_v[2] = 1'b1;
              dec[2]   = byte_in;
            end
          end
        end
        default: begin
          if (byte_in == hrlc_pkg::CH_PCT) begin
            n.esc = hrlc_pkg::ESC_PCT;
          end else begin
            dec_v[0] = 1'b1;
            dec[0]   = byte_in;
          end
        end
      endcase
    end

    for (int k = 0; k < 3; k++) begin
      if (dec_v[k]) begin
        if (!n.first_seen) begin
          n.first_seen  = 1'b1;
          n.first_slash = (dec[k] == hrlc_pkg::CH_SLASH);
        end else if (!n.name_cut) begin
          if (dec[k] == hrlc_pkg::CH_NUL) begin
            n.name_cut = 1'b1;
          end else begin
            if (nc < LEN_CAP) nc = nc + 1'b1;
            if (!hrlc_pkg::is_word(dec[k])) n.name_ok = 1'b0;
            if (n.info_match < hrlc_pkg::INFO_LEN &&
                dec[k] == hrlc_pkg::info_char(n.info_match[1:0])) begin
              n.info_match = n.info_match + 3'd1;
            end else begin
              n.info_match = hrlc_pkg::MATCH_FAIL;
            end
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st          <= hrlc_pkg::clear_state();
      name_count  <= '0;
      query_count <= '0;
    end else if (step) begin
      st          <= n;
      name_count  <= nc;
      query_count <= qc;
    end
  end

endmodule

[sv/hrlc_verdict.sv]
module hrlc_verdict #(
  parameter int NAME_LIMIT = 1024,
  localparam int CW = $clog2(NAME_LIMIT)
) (
  input  hrlc_pkg::line_state_t st,
  input  logic [CW-1:0]         name_count,
  input  logic [CW-1:0]         query_count,
  output hrlc_pkg::verdict_t    res
);

  localparam logic [CW-1:0] LEN_CAP = CW'(NAME_LIMIT - 1);
  localparam logic [16:0]   SHOW_MAX = 17'((1 << hrlc_pkg::LEN_W) - 1);

  logic [16:0] name_ext;
  logic [16:0] query_ext;

  assign name_ext  = 17'(name_count);
  assign query_ext = 17'(query_count);

  always_comb begin
    res.outcome    = hrlc_pkg::OUT_REJECT;
    res.error_code = hrlc_pkg::ERR_NONE;
    if (st.phase != hrlc_pkg::PH_AFTER) begin
      res.error_code = hrlc_pkg::ERR_MALFORMED;
    end else if (st.method_match != hrlc_pkg::GET_LEN) begin
      res.error_code = hrlc_pkg::ERR_NOT_GET;
    end else if (!st.first_slash || name_count >= LEN_CAP) begin
      res.error_code = hrlc_pkg::ERR_BAD_NAME;
    end else if (query_count >= LEN_CAP) begin
      res.error_code = hrlc_pkg::ERR_QUERY_LONG;
    end else if (st.info_match == hrlc_pkg::INFO_LEN) begin
      res.outcome = hrlc_pkg::OUT_INFO;
    end else if (!st.name_ok) begin
      res.outcome = hrlc_pkg::OUT_BAD_NAME;
    end else if (!st.prefix_ok || !st.query_ok ||
                 query_count < CW'(hrlc_pkg::PREFIX_LEN)) begin
      res.outcome = hrlc_pkg::OUT_BAD_QUERY;
    end else begin
      res.outcome = hrlc_pkg::OUT_RUN;
    end
    res.name_length  = (name_ext > SHOW_MAX) ? SHOW_MAX[hrlc_pkg::LEN_W-1:0]
                                             : name_ext[hrlc_pkg::LEN_W-1:0];
    res.query_length = (query_ext > SHOW_MAX) ? SHOW_MAX[hrlc_pkg::LEN_W-1:0]
                                              : query_ext[hrlc_pkg::LEN_W-1:0];
  end

endmodule

[sv/http_request_line_checker.sv]
// A byte accepted into the input stage register is parsed from there; a CR or LF beat
//   has its verdict captured in the output register when it leaves the input stage.
// Throughput: one byte per cycle; the input stalls only when a verdict is due
//   while the output register still holds one that is stalled.
// Reset (rst, synchronous): parser back to the method phase, both registers empty.
module http_request_line_checker #(
  parameter int NAME_LIMIT = 1024
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] line_byte,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [2:0] outcome,
  output logic [2:0] error_code,
  output logic [9:0] name_length,
  output logic [9:0] query_length
);

  localparam int CW = $clog2(NAME_LIMIT);

  logic                  s_valid;
  logic [7:0]            s_byte;
  logic                  adv;
  logic                  emit;
  logic                  out_free;
  hrlc_pkg::line_state_t st;
  logic [CW-1:0]         name_count;
  logic [CW-1:0]         query_count;
  hrlc_pkg::verdict_t    res_next;
  hrlc_pkg::verdict_t    res;

  assign out_free = !out_valid || !out_stall;
  assign adv      = s_valid && (!emit || out_free);
  assign in_stall = s_valid && !adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      s_valid <= 1'b0;
    end else if (!in_stall) begin
      s_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) s_byte <= line_byte;
  end

  hrlc_parse #(.NAME_LIMIT(NAME_LIMIT)) u_parse (
    .clk         (clk),
    .rst         (rst),
    .step        (adv),
    .byte_in     (s_byte),
    .st          (st),
    .name_count  (name_count),
    .query_count (query_count),
    .emit        (emit)
  );

  hrlc_verdict #(.NAME_LIMIT(NAME_LIMIT)) u_verdict (
    .st          (st),
    .name_count  (name_count),
    .query_count (query_count),
    .res         (res_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv && emit) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && emit) res <= res_next;
  end

  assign outcome      = res.outcome;
  assign error_code   = res.error_code;
  assign name_length  = res.name_length;
  assign query_length = res.query_length;

endmodule

[sv/hrlc_checker.sv]
module hrlc_checker (
  input logic       clk,
  input logic       rst,
  input logic       out_valid,
  input logic       out_stall,
  input logic [2:0] outcome,
  input logic [2:0] error_code,
  input logic [9:0] name_length,
  input logic [9:0] query_length
);

  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("output beat present after reset");

  a_hold_valid: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid)
    else $error("stalled output beat dropped");

  a_hold_data: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> $stable(outcome) && $stable(error_code) &&
      $stable(name_length) && $stable(query_length))
    else $error("stalled output beat changed");

  a_err_only_reject: assert property (@(posedge clk) disable iff (rst)
    out_valid && outcome != hrlc_pkg::OUT_REJECT |-> error_code == hrlc_pkg::ERR_NONE)
    else $error("error code on accepted request");

  a_reject_has_err: assert property (@(posedge clk) disable iff (rst)
    out_valid && outcome == hrlc_pkg::OUT_REJECT |->
      error_code != hrlc_pkg::ERR_NONE && error_code <= hrlc_pkg::ERR_QUERY_LONG)
    else $error("rejection without a valid reason");

endmodule

bind http_request_line_checker hrlc_checker u_hrlc_checker (.*);

[test/testbench.sv]
`timescale 1ns / 100ps

module testbench;

  localparam int NAME_CAP    = 1023;
  localparam int CYCLE_LIMIT = 200000;
  localparam int PROBES      = 29;

  localparam logic [23:0] GET_WORD    = "get";
  localparam logic [31:0] INFO_WORD   = "info";
  localparam logic [71:0] PREFIX_WORD = "filename=";

  typedef struct {
    logic [2:0] phase;
    logic [2:0] get_pos;
    logic [1:0] esc;
    logic [7:0] held;
    bit         seen_first;
    bit         lead_slash;
    int         name_cnt;
    bit         name_clean;
    bit         name_cut;
    logic [2:0] info_pos;
    int         query_cnt;
    bit         prefix_good;
    bit         query_clean;
    bit         cut;
    bit         cr_seen;
  } line_state_t;

  typedef struct {
    string              head;
    logic [7:0]         fill;
    int                 fill_n;
    string              tail;
    bit                 typed;
    hrlc_pkg::verdict_t want;
  } probe_t;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       in_valid = 1'b0;
  logic       in_stall;
  logic [7:0] line_byte = 8'd0;
  logic       out_valid;
  logic       out_stall = 1'b0;
  logic [2:0] outcome;
  logic [2:0] error_code;
  logic [9:0] name_length;
  logic [9:0] query_length;

  line_state_t        line_state;
  hrlc_pkg::verdict_t pending_verdicts[$];
  hrlc_pkg::verdict_t typed_verdict;
  bit                 typed_armed;
  logic [7:0]         line_buf[$];
  bit                 quiet;
  int                 errors = 0;
  int                 cycles = 0;

  string word_set = "0123456789abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ_";
  string hex_set  = "0123456789abcdefABCDEF";
  string verb     = "GET";

  probe_t probes [PROBES] = '{
    '{"\n", 8'h00, 0, "", 1'b1,
      '{hrlc_pkg::OUT_REJECT, hrlc_pkg::ERR_MALFORMED, 10'd0, 10'd0}},
    '{"GET /info HTTP/1.0\015\n", 8'h00, 0, "", 1'b1,
      '{hrlc_pkg::OUT_INFO, hrlc_pkg::ERR_NONE, 10'd4, 10'd0}},
    '{"gEt /prog?filename=abc_9 HTTP/1.1\n", 8'h00, 0, "", 1'b1,
      '{hrlc_pkg::OUT_RUN, hrlc_pkg::ERR_NONE, 10'd4, 10'd14}},
    '{"POST /x?filename=a \n", 8'h00, 0, "", 1'b1,
      '{hrlc_pkg::OUT_REJECT, hrlc_pkg::ERR_NOT_GET, 10'd1, 10'd10}},
    '{" /x \n", 8'h00, 0, "", 1'b1,
      '{hrlc_pkg::OUT_REJECT, hrlc_pkg::ERR_NOT_GET, 10'd1, 10'd0}},
    '{"GETT /info \n", 8'h00, 0, "", 1'b1,
      '{hrlc_pkg::OUT_REJECT, hrlc_pkg::ERR_NOT_GET, 10'd4, 10'd0}},
    '{"GET x?filename=a \n", 8'h00, 0, "", 1'b1,
      '{hrlc_pkg::OUT_REJECT, hrlc_pkg::ERR_BAD_NAME, 10'd0, 10'd10}},
    '{"GET /a.b?filename=ok \n", 8'h00, 0, "", 1'b0, '0},
    '{"GET /ab?filename=o-k \n", 8'h00, 0, "", 1'b0, '0},
    '{"GET /ab?file=x \n", 8'h00, 0, "", 1'b0, '0},
    '{"GET /abc \n", 8'h00, 0, "", 1'b0, '0},
    '{"GET /info?filename=x.y \015\n", 8'h00, 0, "", 1'b0, '0},
    '{"GET /%41%62c%2 \n", 8'h00, 0, "", 1'b0, '0},
    '{"GET %2Finfo \n", 8'h00, 0, "", 1'b0, '0},
    '{"GET /%zz%4g%%41 \n", 8'h00, 0, "", 1'b0, '0},
    '{"GET /%FF%e9?filename=a \n", 8'h00, 0, "", 1'b0, '0},
    '{"GET /ab%00cd?filename=x \n", 8'h00, 0, "", 1'b0, '0},
    '{"GET /a", 8'h00, 1, "junk \015\n", 1'b1,
      '{hrlc_pkg::OUT_REJECT, hrlc_pkg::ERR_MALFORMED, 10'd1, 10'd0}},
    '{"GET\t\t/ab?filename=q\tx\n", 8'h00, 0, "", 1'b0, '0},
    '{"GET /ab%4?filename=z \n", 8'h00, 0, "", 1'b0, '0},
    '{"GET /ab\n", 8'h00, 0, "", 1'b1,
      '{hrlc_pkg::OUT_REJECT, hrlc_pkg::ERR_MALFORMED, 10'd2, 10'd0}},
    '{"\015\015\n", 8'h00, 0, "", 1'b1,
      '{hrlc_pkg::OUT_REJECT, hrlc_pkg::ERR_MALFORMED, 10'd0, 10'd0}},
    '{"\377\200\177 \001\n", 8'h00, 0, "", 1'b0, '0},
    '{"GET /?filename=abc \n", 8'h00, 0, "", 1'b1,
      '{hrlc_pkg::OUT_RUN, hrlc_pkg::ERR_NONE, 10'd0, 10'd12}},
    '{"GET /", "a", 1022, "?filename=x \n", 1'b1,
      '{hrlc_pkg::OUT_RUN, hrlc_pkg::ERR_NONE, 10'd1022, 10'd10}},
    '{"GET /", "a", 1023, " \n", 1'b1,
      '{hrlc_pkg::OUT_REJECT, hrlc_pkg::ERR_BAD_NAME, 10'd1023, 10'd0}},
    '{"GET /", "b", 1500, "?filename=z \n", 1'b1,
      '{hrlc_pkg::OUT_REJECT, hrlc_pkg::ERR_BAD_NAME, 10'd1023, 10'd10}},
    '{"GET /a?filename=", "c", 1014, " \n", 1'b1,
      '{hrlc_pkg::OUT_REJECT, hrlc_pkg::ERR_QUERY_LONG, 10'd1, 10'd1023}},
    '{"GET /a?", "d", 1022, " \n", 1'b0, '0}
  };

  http_request_line_checker u_top (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .line_byte    (line_byte),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .outcome      (outcome),
    .error_code   (error_code),
    .name_length  (name_length),
    .query_length (query_length)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic bit word_char(logic [7:0] c);
    return (c >= "0" && c <= "9") || (c >= "a" && c <= "z") ||
           (c >= "A" && c <= "Z") || c == "_";
  endfunction

  function automatic bit hex_digit(logic [7:0] c);
    return (c >= "0" && c <= "9") || (c >= "a" && c <= "f") || (c >= "A" && c <= "F");
  endfunction

  function automatic logic [3:0] nibble(logic [7:0] c);
    logic [7:0] v;
    if (c <= "9") v = c - "0";
    else if (c >= "a") v = c - "a" + 8'd10;
    else v = c - "A" + 8'd10;
    return v[3:0];
  endfunction

  function automatic bit gap_char(logic [7:0] c);
    return c == hrlc_pkg::CH_SP || c == hrlc_pkg::CH_TAB;
  endfunction

  function automatic void new_line();
    line_state.phase       = hrlc_pkg::PH_METHOD;
    line_state.get_pos     = '0;
    line_state.esc         = hrlc_pkg::ESC_IDLE;
    line_state.held        = '0;
    line_state.seen_first  = 1'b0;
    line_state.lead_slash  = 1'b0;
    line_state.name_cnt    = 0;
    line_state.name_clean  = 1'b1;
    line_state.name_cut    = 1'b0;
    line_state.info_pos    = '0;
    line_state.query_cnt   = 0;
    line_state.prefix_good = 1'b1;
    line_state.query_clean = 1'b1;
    line_state.cut         = 1'b0;
  endfunction

  function automatic void name_char(logic [7:0] c);
    if (!line_state.seen_first) begin
      line_state.seen_first = 1'b1;
      line_state.lead_slash = (c == hrlc_pkg::CH_SLASH);
      return;
    end
    if (line_state.name_cut) return;
    if (c == hrlc_pkg::CH_NUL) begin
      line_state.name_cut = 1'b1;
      return;
    end
    if (line_state.name_cnt < NAME_CAP) line_state.name_cnt++;
    if (!word_char(c)) line_state.name_clean = 1'b0;
    if (line_state.info_pos < hrlc_pkg::INFO_LEN &&
        c == INFO_WORD[8*(3-int'(line_state.info_pos)) +: 8]) line_state.info_pos++;
    else line_state.info_pos = hrlc_pkg::MATCH_FAIL;
  endfunction

  // a pending escape that cannot complete is taken literally
  function automatic void flush_escape();
    if (line_state.esc != hrlc_pkg::ESC_IDLE) name_char(hrlc_pkg::CH_PCT);
    if (line_state.esc == hrlc_pkg::ESC_DIGIT) name_char(line_state.held);
    line_state.esc = hrlc_pkg::ESC_IDLE;
  endfunction

  function automatic void path_char(logic [7:0] c);
    if (line_state.esc == hrlc_pkg::ESC_PCT) begin
      if (hex_digit(c)) begin
        line_state.held = c;
        line_state.esc  = hrlc_pkg::ESC_DIGIT;
        return;
      end
      flush_escape();
    end else if (line_state.esc == hrlc_pkg::ESC_DIGIT) begin
      if (hex_digit(c)) begin
        name_char({nibble(line_state.held), nibble(c)});
        line_state.esc = hrlc_pkg::ESC_IDLE;
        return;
      end
      flush_escape();
    end
    if (c == hrlc_pkg::CH_PCT) line_state.esc = hrlc_pkg::ESC_PCT;
    else name_char(c);
  endfunction

  function automatic void query_char(logic [7:0] c);
    if (line_state.query_cnt < hrlc_pkg::PREFIX_LEN) begin
      if (c != PREFIX_WORD[8*(8-line_state.query_cnt) +: 8]) line_state.prefix_good = 1'b0;
    end else if (!word_char(c)) begin
      line_state.query_clean = 1'b0;
    end
    if (line_state.query_cnt < NAME_CAP) line_state.query_cnt++;
  endfunction

  function automatic hrlc_pkg::verdict_t line_verdict();
    hrlc_pkg::verdict_t v;
    v.outcome    = hrlc_pkg::OUT_REJECT;
    v.error_code = hrlc_pkg::ERR_NONE;
    if (line_state.phase != hrlc_pkg::PH_AFTER) v.error_code = hrlc_pkg::ERR_MALFORMED;
    else if (line_state.get_pos != hrlc_pkg::GET_LEN) v.error_code = hrlc_pkg::ERR_NOT_GET;
    else if (!line_state.lead_slash) v.error_code = hrlc_pkg::ERR_BAD_NAME;
    else if (line_state.name_cnt >= NAME_CAP) v.error_code = hrlc_pkg::ERR_BAD_NAME;
    else if (line_state.query_cnt >= NAME_CAP) v.error_code = hrlc_pkg::ERR_QUERY_LONG;
    else if (line_state.info_pos == hrlc_pkg::INFO_LEN) v.outcome = hrlc_pkg::OUT_INFO;
    else if (!line_state.name_clean) v.outcome = hrlc_pkg::OUT_BAD_NAME;
    else if (!line_state.prefix_good || !line_state.query_clean ||
             line_state.query_cnt < hrlc_pkg::PREFIX_LEN) v.outcome = hrlc_pkg::OUT_BAD_QUERY;
    else v.outcome = hrlc_pkg::OUT_RUN;
    v.name_length  = 10'(line_state.name_cnt);
    v.query_length = 10'(line_state.query_cnt);
    return v;
  endfunction

  // returns 1 when the byte closes a line, with its verdict in v
  function automatic bit parse_byte(input logic [7:0] c, output hrlc_pkg::verdict_t v);
    logic [7:0] lc;
    bit         was_cr;
    was_cr = line_state.cr_seen;
    line_state.cr_seen = 1'b0;
    if (c == hrlc_pkg::CH_LF && was_cr) return 1'b0;
    if (c == hrlc_pkg::CH_LF || c == hrlc_pkg::CH_CR) begin
      v = line_verdict();
      new_line();
      line_state.cr_seen = (c == hrlc_pkg::CH_CR);
      return 1'b1;
    end
    if (line_state.cut) return 1'b0;
    if (c == hrlc_pkg::CH_NUL) begin
      line_state.cut = 1'b1;
      return 1'b0;
    end
    case (line_state.phase)
      hrlc_pkg::PH_METHOD: begin
        lc = (c >= "A" && c <= "Z") ? c + 8'd32 : c;
        if (gap_char(c)) line_state.phase = hrlc_pkg::PH_GAP;
        else if (line_state.get_pos < hrlc_pkg::GET_LEN &&
                 lc == GET_WORD[8*(2-int'(line_state.get_pos)) +: 8]) line_state.get_pos++;
        else line_state.get_pos = hrlc_pkg::MATCH_FAIL;
      end
      hrlc_pkg::PH_GAP: begin
        if (!gap_char(c)) begin
          if (c == hrlc_pkg::CH_QM) line_state.phase = hrlc_pkg::PH_QUERY;
          else begin
            line_state.phase = hrlc_pkg::PH_PATH;
            path_char(c);
          end
        end
      end
      hrlc_pkg::PH_PATH: begin
        if (gap_char(c)) begin
          flush_escape();
          line_state.phase = hrlc_pkg::PH_AFTER;
        end else if (c == hrlc_pkg::CH_QM) begin
          flush_escape();
          line_state.phase = hrlc_pkg::PH_QUERY;
        end else begin
          path_char(c);
        end
      end
      hrlc_pkg::PH_QUERY: begin
        if (gap_char(c)) line_state.phase = hrlc_pkg::PH_AFTER;
        else query_char(c);
      end
      default: ;
    endcase
    return 1'b0;
  endfunction

  task automatic report(input string what);
    errors++;
    if (errors <= 50) $display("MISMATCH at %0t: %s", $time, what);
  endtask

  task automatic send_beat(input logic [7:0] c);
    hrlc_pkg::verdict_t v;
    in_valid  <= 1'b1;
    line_byte <= c;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    if (parse_byte(c, v)) begin
      if (typed_armed) begin
        pending_verdicts.push_back(typed_verdict);
        typed_armed = 1'b0;
      end else begin
        pending_verdicts.push_back(v);
      end
    end
    if (!quiet && $urandom_range(0, 99) < 5) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_verdicts.size() != 0) @(posedge clk);
  endtask

  function automatic void push_text(string s);
    for (int i = 0; i < s.len(); i++) line_buf.push_back(s[i]);
  endfunction

  function automatic logic [7:0] rand_word();
    return word_set[$urandom_range(0, word_set.len() - 1)];
  endfunction

  function automatic logic [7:0] rand_hex();
    return hex_set[$urandom_range(0, hex_set.len() - 1)];
  endfunction

  function automatic void push_gap();
    repeat ($urandom_range(1, 2))
      line_buf.push_back($urandom_range(0, 1) ? hrlc_pkg::CH_SP : hrlc_pkg::CH_TAB);
  endfunction

  // mostly well-formed request lines with random content, some noise
  task automatic build_random_line();
    int         pick;
    logic [7:0] c;
    line_buf.delete();
    if ($urandom_range(0, 99) < 8) begin
      repeat ($urandom_range(0, 14)) line_buf.push_back(8'($urandom_range(0, 255)));
    end else begin
      pick = $urandom_range(0, 9);
      if (pick == 1) push_text("GE");
      else if (pick == 2) push_text("GETX");
      else if (pick == 3) repeat ($urandom_range(1, 4)) line_buf.push_back(rand_word());
      else if (pick != 0) begin
        for (int i = 0; i < verb.len(); i++)
          line_buf.push_back($urandom_range(0, 1) ? verb[i] : verb[i] + 8'd32);
      end
      push_gap();
      pick = $urandom_range(0, 19);
      if (pick == 0) push_text($urandom_range(0, 1) ? "%2f" : "%2F");
      else if (pick == 1) line_buf.push_back(rand_word());
      else if (pick != 2) line_buf.push_back(hrlc_pkg::CH_SLASH);
      if ($urandom_range(0, 5) == 0) begin
        push_text("info");
      end else begin
        repeat ($urandom_range(0, 8)) begin
          pick = $urandom_range(0, 99);
          if (pick < 70) begin
            line_buf.push_back(rand_word());
          end else if (pick < 78) begin
            line_buf.push_back(hrlc_pkg::CH_PCT);
            line_buf.push_back(rand_hex());
            line_buf.push_back(rand_hex());
          end else if (pick < 84) begin
            line_buf.push_back(hrlc_pkg::CH_PCT);
            if ($urandom_range(0, 1)) line_buf.push_back(rand_hex());
            line_buf.push_back(8'($urandom_range(33, 126)));
          end else if (pick < 88) begin
            push_text("%00");
          end else begin
            c = 8'($urandom_range(1, 255));
            if (c == hrlc_pkg::CH_LF || c == hrlc_pkg::CH_CR) c = ".";
            line_buf.push_back(c);
          end
        end
      end
      pick = $urandom_range(0, 19);
      if (pick < 12) begin
        push_text("?filename=");
        repeat ($urandom_range(0, 8)) begin
          if ($urandom_range(0, 9) != 0) line_buf.push_back(rand_word());
          else line_buf.push_back(8'($urandom_range(33, 126)));
        end
      end else if (pick < 15) begin
        line_buf.push_back(hrlc_pkg::CH_QM);
        repeat ($urandom_range(0, 12)) line_buf.push_back(rand_word());
      end else if (pick == 15) begin
        push_text("?filen");
      end
      if ($urandom_range(0, 9) != 0) begin
        push_gap();
        push_text("HTTP/1.1");
      end
      if ($urandom_range(0, 29) == 0) begin
        line_buf.push_back(hrlc_pkg::CH_NUL);
        push_text("rest");
      end
    end
    pick = $urandom_range(0, 19);
    if (pick < 10) begin
      line_buf.push_back(hrlc_pkg::CH_LF);
    end else if (pick < 17) begin
      line_buf.push_back(hrlc_pkg::CH_CR);
      line_buf.push_back(hrlc_pkg::CH_LF);
    end else if (pick < 19) begin
      line_buf.push_back(hrlc_pkg::CH_CR);
    end else begin
      line_buf.push_back(hrlc_pkg::CH_LF);
      line_buf.push_back(hrlc_pkg::CH_LF);
    end
  endtask

  always @(posedge clk) begin : verdict_check
    hrlc_pkg::verdict_t want;
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (pending_verdicts.size() == 0) begin
          report("verdict with none pending");
        end else begin
          want = pending_verdicts.pop_front();
          if (outcome !== want.outcome)
            report($sformatf("outcome %0d, want %0d", outcome, want.outcome));
          if (error_code !== want.error_code)
            report($sformatf("error_code %0d, want %0d", error_code, want.error_code));
          if (name_length !== want.name_length)
            report($sformatf("name_length %0d, want %0d", name_length, want.name_length));
          if (query_length !== want.query_length)
            report($sformatf("query_length %0d, want %0d", query_length, want.query_length));
        end
      end
      out_stall <= !quiet && ($urandom_range(0, 99) < 12);
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles == CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  initial begin
    int sent;
    int lines;
    quiet = 1'b0;
    typed_armed = 1'b0;
    new_line();
    line_state.cr_seen = 1'b0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    foreach (probes[p]) begin
      line_buf.delete();
      push_text(probes[p].head);
      repeat (probes[p].fill_n) line_buf.push_back(probes[p].fill);
      push_text(probes[p].tail);
      typed_armed   = probes[p].typed;
      typed_verdict = probes[p].want;
      foreach (line_buf[i]) send_beat(line_buf[i]);
      typed_armed = 1'b0;
    end
    drain();

    sent  = 0;
    lines = 0;
    while (sent < 500 || lines < 40) begin
      quiet = (lines >= 12 && lines < 24);
      build_random_line();
      foreach (line_buf[i]) send_beat(line_buf[i]);
      sent += line_buf.size();
      lines++;
      if (lines % 15 == 0) drain();
    end
    quiet = 1'b0;

    drain();
    repeat (8) @(posedge clk);
    if (errors == 0) $display("Test completed successfully");
    else $display("Test completed with failures");
    $finish;
  end

endmodule
